// ----- design/carrot_chase_heading_error_defines.svh -----
// Assertion macros shared by the carrot-chase heading error block.
// Expects signals clk and rst_n in the scope that uses them.
`ifndef CARROT_CHASE_HEADING_ERROR_DEFINES_SVH
`define CARROT_CHASE_HEADING_ERROR_DEFINES_SVH
`ifndef ASSERT_OFF
`define CCHE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CCHE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CCHE_ASSERT_IMP(lbl, ante, cons, msg)
`define CCHE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/cche_pkg.sv -----
// Shared types, constants and the arctangent table for the carrot-chase block.
// No dependencies.
package cche_pkg;

    localparam int DW = 36;     // CORDIC x/y datapath width
    localparam int ZW = 22;     // angle width, units of 2^-16 rad
    localparam int MB = 18;     // multiplier B operand width
    localparam int PW = DW + MB;

    typedef logic signed [DW-1:0] cdat_t;
    typedef logic signed [ZW-1:0] angle_t;
    typedef logic signed [MB-1:0] mulb_t;
    typedef logic signed [PW-1:0] prod_t;

    localparam angle_t PI_Q16      = 22'sd205887;
    localparam angle_t TWO_PI_Q16  = 22'sd411774;
    localparam angle_t HALF_PI_Q16 = 22'sd102944;
    localparam angle_t PI_Q13      = 22'sd25736;
    localparam angle_t TWO_PI_Q13  = 22'sd51472;
    localparam mulb_t  INVK_Q16    = 18'sd39797;
    localparam cdat_t  INVK_Q30    = 36'sd652032874;
    localparam logic signed [15:0] HE_LIMIT = 16'sd25736;

    // configuration register indexes
    localparam logic [1:0] CFG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] CFG_ARRIVE    = 2'd1;
    localparam logic [1:0] CFG_COUNT     = 2'd2;

    // input item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_POSE = 1'b1;

    typedef struct packed {
        logic start;
        logic rotate;
    } cordic_cmd_t;

    typedef struct packed {
        logic done;
    } cordic_stat_t;

    function automatic angle_t atan_lut(input logic [4:0] k);
        angle_t a;
        case (k)
            5'd0:    a = 22'sd51472;
            5'd1:    a = 22'sd30386;
            5'd2:    a = 22'sd16055;
            5'd3:    a = 22'sd8150;
            5'd4:    a = 22'sd4091;
            5'd5:    a = 22'sd2047;
            5'd6:    a = 22'sd1024;
            5'd7:    a = 22'sd512;
            5'd8:    a = 22'sd256;
            5'd9:    a = 22'sd128;
            5'd10:   a = 22'sd64;
            5'd11:   a = 22'sd32;
            5'd12:   a = 22'sd16;
            5'd13:   a = 22'sd8;
            5'd14:   a = 22'sd4;
            5'd15:   a = 22'sd2;
            5'd16:   a = 22'sd1;
            default: a = 22'sd0;
        endcase
        return a;
    endfunction

endpackage

// ----- design/carrot_chase_heading_error.sv -----
// Carrot-chase guidance top level: waypoint table, sequencer, shared CORDIC and multiplier.
// Depends on cche_pkg, cche_ram, cche_mul, cche_cordic and the assertion macro header.
//
// Usage: one input channel (in_valid/in_stall) carries items. A load item (func = 0)
// writes one waypoint into the table and gives no result. A pose
// item (func = 1) gives one result on the output channel (out_valid/out_stall): the
// heading error toward the carrot and the current waypoint index.
// A pose item makes five passes through the one CORDIC unit (three vectoring,
// two rotation), besides the angle wrap steps and the table reads.
// in_stall is high from acceptance of a pose until its result enters the output register.
// The output register holds a result until it transfers; the next item is accepted
// meanwhile, and a second result waits in the sequencer while the receiver stalls.
// Reset clears the waypoint index and loads the default lookahead (1 m), arrival
// radius (0.3 m) and waypoint count (15). The table holds no value after reset:
// write every waypoint in use before the first pose.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`include "carrot_chase_heading_error_defines.svh"
module carrot_chase_heading_error import cche_pkg::*; #(
    parameter int MAX_WAYPOINTS = 16,
    parameter int CORDIC_ITERS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [3:0]         wp_slot,
    input  logic signed [31:0] wp_x,
    input  logic signed [31:0] wp_y,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] yaw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] heading_error,
    output logic [3:0]         target_index
);

    localparam int IW  = $clog2(MAX_WAYPOINTS);
    localparam int NW  = IW + 1;
    localparam int SLW = (IW > 4) ? IW : 4;
    localparam int SW  = SLW + 1;
    localparam int CW  = (NW > 5) ? NW : 5;
    localparam int AC  = 63;

    typedef enum logic [4:0] {
        S_IDLE, S_MOD, S_RDN, S_NXD, S_ABS, S_SQ, S_ARR, S_RDC, S_CD, S_RDN2, S_N2D,
        S_V1, S_V1W, S_MAG, S_RU, S_V2, S_V2W, S_WB, S_R1, S_R1W, S_CBM, S_LEN,
        S_WT, S_R2, S_R2W, S_MX, S_MY, S_CYD, S_V3, S_V3W, S_WH, S_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [30:0] lookahead_reg;
    logic [30:0] arrive_radius_reg;
    logic [4:0]  waypoint_count_reg;

    // sequencer registers
    logic [IW-1:0]      cur_reg;
    logic [IW-1:0]      cidx_reg;
    logic [IW-1:0]      nxt_reg;
    logic [NW:0]        dsh_reg;
    logic [NW-1:0]      rem_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [15:0] yaw_reg;
    logic signed [31:0] cw_x_reg;
    logic signed [31:0] cw_y_reg;
    logic signed [31:0] nw_x_reg;
    logic signed [31:0] nw_y_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic [30:0]        ax_reg;
    logic [30:0]        ay_reg;
    logic               far_reg;
    logic [2:0]         ph_reg;
    logic [AC-1:0]      rsq_reg;
    logic [AC-1:0]      dsq_reg;
    cdat_t              ru_reg;
    cdat_t              len_reg;
    angle_t             th_reg;
    angle_t             theta_reg;
    angle_t             ang_reg;
    mulb_t              cb_reg;
    mulb_t              ct_reg;
    mulb_t              st_reg;

    // output register
    logic               out_valid_reg;
    logic signed [15:0] heading_reg;
    logic [3:0]         tidx_reg;

    // unit connections
    logic [IW-1:0] rd_addr;
    logic [63:0]   rd_data;
    logic          wr_en;
    logic [SW-1:0] slot_ext;
    cordic_cmd_t   cd_cmd;
    cordic_stat_t  cd_stat;
    cdat_t         cd_x_in;
    cdat_t         cd_y_in;
    angle_t        cd_z_in;
    cdat_t         cd_x;
    cdat_t         cd_y;
    angle_t        cd_z;
    cdat_t         mul_a;
    mulb_t         mul_b;
    prod_t         prod;

    // combinational helpers
    logic [CW-1:0]  cnt_ext;
    logic [NW-1:0]  n_eff;
    logic [NW:0]    mod_t;
    logic [NW-1:0]  nxt_inc;
    cdat_t          dx;
    cdat_t          dy;
    cdat_t          adx;
    cdat_t          ady;
    logic [2:0]     pidx;
    logic [AC-1:0]  term;
    logic           arrived;
    logic           wrap_hi;
    logic           wrap_lo;
    cdat_t          cb_full;
    logic signed [PW-17:0] prod_sh;
    logic signed [PW-16:0] cs_sum;
    logic signed [31:0]    cs_sat;
    angle_t         h13;
    angle_t         h13_adj;
    logic [SLW-1:0] cidx_ext;
    logic           out_free;
    logic           in_acc;

    function automatic cdat_t sx32(input logic signed [31:0] v);
        return {{(DW-32){v[31]}}, v};
    endfunction

    // memories and shared units
    cche_ram #(
        .WIDTH(64),
        .DEPTH(MAX_WAYPOINTS)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(slot_ext[IW-1:0]),
        .wr_data({wp_x, wp_y}),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    cche_cordic #(
        .ITERS(CORDIC_ITERS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cd_cmd),
        .x_in (cd_x_in),
        .y_in (cd_y_in),
        .z_in (cd_z_in),
        .stat (cd_stat),
        .x_out(cd_x),
        .y_out(cd_y),
        .z_out(cd_z)
    );

    cche_mul u_mul (
        .clk  (clk),
        .mul_a(mul_a),
        .mul_b(mul_b),
        .prod (prod)
    );

    // input handshake and table write
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign slot_ext = SW'(wp_slot);
    assign wr_en    = in_acc && (func == FUNC_LOAD) && (slot_ext < SW'(MAX_WAYPOINTS));

    // effective waypoint count, clamped to 1..MAX_WAYPOINTS
    always_comb
    begin
        cnt_ext = CW'(waypoint_count_reg);
        if (cnt_ext == '0)
        begin
            n_eff = NW'(1);
        end
        else if (cnt_ext > CW'(MAX_WAYPOINTS))
        begin
            n_eff = NW'(MAX_WAYPOINTS);
        end
        else
        begin
            n_eff = NW'(cnt_ext);
        end
    end

    // one restoring remainder step, and the wrap increment
    assign mod_t   = {rem_reg, dsh_reg[NW]};
    assign nxt_inc = NW'(nxt_reg) + NW'(1);

    // arrival distance components
    always_comb
    begin
        dx  = sx32(nw_x_reg) - sx32(px_reg);
        dy  = sx32(nw_y_reg) - sx32(py_reg);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
    end

    // squared-distance accumulation term
    always_comb
    begin
        pidx = ph_reg - 3'd1;
        if (pidx[0] == 1'b0)
        begin
            term = {prod[46:0], 16'b0};
        end
        else
        begin
            term = {10'b0, prod[52:0]};
        end
    end

    assign arrived = !far_reg && (dsq_reg < rsq_reg);

    // angle wrap into (-pi, pi]
    assign wrap_hi = ang_reg > PI_Q16;
    assign wrap_lo = ang_reg <= -PI_Q16;

    // product scaling and carrot saturation
    always_comb
    begin
        prod_sh = prod[PW-1:16];
        cs_sum  = (state_reg == S_MY) ? ((PW-15)'(cw_x_reg) + (PW-15)'(prod_sh))
                                      : ((PW-15)'(cw_y_reg) + (PW-15)'(prod_sh));
        if (cs_sum > (PW-15)'(32'sh7FFFFFFF))
        begin
            cs_sat = 32'sh7FFFFFFF;
        end
        else if (cs_sum < -(PW-15)'(33'sh080000000))
        begin
            cs_sat = 32'sh80000000;
        end
        else
        begin
            cs_sat = cs_sum[31:0];
        end
        cb_full = cd_x >>> 14;
    end

    // final rounding to Q3.13
    always_comb
    begin
        h13 = (ang_reg + 22'sd4) >>> 3;
        if (h13 <= -PI_Q13)
        begin
            h13_adj = h13 + TWO_PI_Q13;
        end
        else if (h13 > PI_Q13)
        begin
            h13_adj = h13 - TWO_PI_Q13;
        end
        else
        begin
            h13_adj = h13;
        end
    end

    assign cidx_ext = SLW'(cidx_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // table read address
    always_comb
    begin
        case (state_reg)
            S_RDC:   rd_addr = cidx_reg;
            default: rd_addr = nxt_reg;
        endcase
    end

    // CORDIC command and operands
    always_comb
    begin
        cd_cmd.start  = 1'b0;
        cd_cmd.rotate = 1'b0;
        cd_x_in       = sx32(cw_x_reg) - sx32(px_reg);
        cd_y_in       = sx32(cw_y_reg) - sx32(py_reg);
        cd_z_in       = ang_reg;
        case (state_reg)
            S_V1:
            begin
                cd_cmd.start = 1'b1;
            end
            S_V2:
            begin
                cd_cmd.start = 1'b1;
                cd_x_in      = sx32(nw_x_reg) - sx32(cw_x_reg);
                cd_y_in      = sx32(nw_y_reg) - sx32(cw_y_reg);
            end
            S_R1, S_R2:
            begin
                cd_cmd.start  = 1'b1;
                cd_cmd.rotate = 1'b1;
                cd_x_in       = INVK_Q30;
                cd_y_in       = '0;
            end
            S_V3:
            begin
                cd_cmd.start = 1'b1;
                cd_x_in      = sx32(cx_reg) - sx32(px_reg);
                cd_y_in      = sx32(cy_reg) - sx32(py_reg);
            end
            default:
            begin
                cd_cmd.start = 1'b0;
            end
        endcase
    end

    // multiplier operands
    always_comb
    begin
        mul_a = cd_x;
        mul_b = INVK_Q16;
        case (state_reg)
            S_SQ:
            begin
                case (ph_reg)
                    3'd0:    begin mul_a = DW'(arrive_radius_reg); mul_b = MB'(arrive_radius_reg[30:16]); end
                    3'd1:    begin mul_a = DW'(arrive_radius_reg); mul_b = MB'(arrive_radius_reg[15:0]); end
                    3'd2:    begin mul_a = DW'(ax_reg); mul_b = MB'(ax_reg[30:16]); end
                    3'd3:    begin mul_a = DW'(ax_reg); mul_b = MB'(ax_reg[15:0]); end
                    3'd4:    begin mul_a = DW'(ay_reg); mul_b = MB'(ay_reg[30:16]); end
                    3'd5:    begin mul_a = DW'(ay_reg); mul_b = MB'(ay_reg[15:0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_CBM:
            begin
                mul_a = ru_reg;
                mul_b = cb_reg;
            end
            S_MX:
            begin
                mul_a = len_reg;
                mul_b = ct_reg;
            end
            S_MY:
            begin
                mul_a = len_reg;
                mul_b = st_reg;
            end
            default:
            begin
                mul_a = cd_x;
            end
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            cur_reg            <= '0;
            out_valid_reg      <= 1'b0;
            lookahead_reg      <= 31'd65536;
            arrive_radius_reg  <= 31'd19661;
            waypoint_count_reg <= 5'd15;
            ph_reg             <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOOKAHEAD: lookahead_reg      <= cfg_data;
                    CFG_ARRIVE:    arrive_radius_reg  <= cfg_data;
                    CFG_COUNT:     waypoint_count_reg <= cfg_data[4:0];
                    default:       ;
                endcase
            end

            // drop the result once it transfers
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && func == FUNC_POSE)
                    begin
                        px_reg    <= pos_x;
                        py_reg    <= pos_y;
                        yaw_reg   <= yaw;
                        dsh_reg   <= {NW'(cur_reg) + NW'(1), 1'b1};
                        rem_reg   <= '0;
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    // next index = (cur + 1) mod n, one bit per cycle
                    if (dsh_reg == {1'b1, NW'(0)})
                    begin
                        nxt_reg   <= rem_reg[IW-1:0];
                        state_reg <= S_RDN;
                    end
                    else
                    begin
                        dsh_reg <= {dsh_reg[NW-1:0], 1'b0};
                        if (mod_t >= (NW+1)'(n_eff))
                        begin
                            rem_reg <= NW'(mod_t - (NW+1)'(n_eff));
                        end
                        else
                        begin
                            rem_reg <= mod_t[NW-1:0];
                        end
                    end
                end
                S_RDN:
                begin
                    state_reg <= S_NXD;
                end
                S_NXD:
                begin
                    nw_x_reg  <= rd_data[63:32];
                    nw_y_reg  <= rd_data[31:0];
                    state_reg <= S_ABS;
                end
                S_ABS:
                begin
                    ax_reg    <= adx[30:0];
                    ay_reg    <= ady[30:0];
                    far_reg   <= (adx[DW-1:31] != '0) || (ady[DW-1:31] != '0);
                    rsq_reg   <= '0;
                    dsq_reg   <= '0;
                    ph_reg    <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    // issue one partial square, accumulate the previous one
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg != 3'd0)
                    begin
                        if (pidx < 3'd2)
                        begin
                            rsq_reg <= rsq_reg + term;
                        end
                        else
                        begin
                            dsq_reg <= dsq_reg + term;
                        end
                    end
                    if (ph_reg == 3'd6)
                    begin
                        state_reg <= S_ARR;
                    end
                end
                S_ARR:
                begin
                    if (arrived)
                    begin
                        cidx_reg <= nxt_reg;
                        nxt_reg  <= (nxt_inc == n_eff) ? '0 : nxt_inc[IW-1:0];
                    end
                    else
                    begin
                        cidx_reg <= cur_reg;
                    end
                    state_reg <= S_RDC;
                end
                S_RDC:
                begin
                    state_reg <= S_CD;
                end
                S_CD:
                begin
                    cw_x_reg  <= rd_data[63:32];
                    cw_y_reg  <= rd_data[31:0];
                    state_reg <= S_RDN2;
                end
                S_RDN2:
                begin
                    state_reg <= S_N2D;
                end
                S_N2D:
                begin
                    nw_x_reg  <= rd_data[63:32];
                    nw_y_reg  <= rd_data[31:0];
                    state_reg <= S_V1;
                end
                S_V1:
                begin
                    state_reg <= S_V1W;
                end
                S_V1W:
                begin
                    if (cd_stat.done)
                    begin
                        th_reg    <= cd_z;
                        state_reg <= S_MAG;
                    end
                end
                S_MAG:
                begin
                    state_reg <= S_RU;
                end
                S_RU:
                begin
                    ru_reg    <= DW'(prod_sh);
                    state_reg <= S_V2;
                end
                S_V2:
                begin
                    state_reg <= S_V2W;
                end
                S_V2W:
                begin
                    if (cd_stat.done)
                    begin
                        theta_reg <= cd_z;
                        ang_reg   <= cd_z - th_reg;
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (wrap_hi)
                    begin
                        ang_reg <= ang_reg - TWO_PI_Q16;
                    end
                    else if (wrap_lo)
                    begin
                        ang_reg <= ang_reg + TWO_PI_Q16;
                    end
                    else
                    begin
                        state_reg <= S_R1;
                    end
                end
                S_R1:
                begin
                    state_reg <= S_R1W;
                end
                S_R1W:
                begin
                    if (cd_stat.done)
                    begin
                        cb_reg    <= (cb_full < 0) ? -cb_full[MB-1:0] : cb_full[MB-1:0];
                        state_reg <= S_CBM;
                    end
                end
                S_CBM:
                begin
                    state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    len_reg   <= DW'(prod_sh) + DW'(lookahead_reg);
                    ang_reg   <= theta_reg;
                    state_reg <= S_WT;
                end
                S_WT:
                begin
                    if (wrap_hi)
                    begin
                        ang_reg <= ang_reg - TWO_PI_Q16;
                    end
                    else if (wrap_lo)
                    begin
                        ang_reg <= ang_reg + TWO_PI_Q16;
                    end
                    else
                    begin
                        state_reg <= S_R2;
                    end
                end
                S_R2:
                begin
                    state_reg <= S_R2W;
                end
                S_R2W:
                begin
                    if (cd_stat.done)
                    begin
                        ct_reg    <= cd_x[31:14];
                        st_reg    <= cd_y[31:14];
                        state_reg <= S_MX;
                    end
                end
                S_MX:
                begin
                    state_reg <= S_MY;
                end
                S_MY:
                begin
                    cx_reg    <= cs_sat;
                    state_reg <= S_CYD;
                end
                S_CYD:
                begin
                    cy_reg    <= cs_sat;
                    state_reg <= S_V3;
                end
                S_V3:
                begin
                    state_reg <= S_V3W;
                end
                S_V3W:
                begin
                    if (cd_stat.done)
                    begin
                        ang_reg   <= cd_z - {{(ZW-19){yaw_reg[15]}}, yaw_reg, 3'b000};
                        state_reg <= S_WH;
                    end
                end
                S_WH:
                begin
                    if (wrap_hi)
                    begin
                        ang_reg <= ang_reg - TWO_PI_Q16;
                    end
                    else if (wrap_lo)
                    begin
                        ang_reg <= ang_reg + TWO_PI_Q16;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        heading_reg   <= h13_adj[15:0];
                        tidx_reg      <= cidx_ext[3:0];
                        out_valid_reg <= 1'b1;
                        cur_reg       <= cidx_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign heading_error = heading_reg;
    assign target_index  = tidx_reg;

    // checks
    `CCHE_ASSERT_IMP(a_he_range, out_valid, (heading_error > -HE_LIMIT) && (heading_error <= HE_LIMIT), "heading error out of range")
    `CCHE_ASSERT_IMP(a_cordic_wait, cd_stat.done, (state_reg == S_V1W) || (state_reg == S_V2W) || (state_reg == S_R1W) || (state_reg == S_R2W) || (state_reg == S_V3W), "CORDIC finished outside a wait state")
    `CCHE_ASSERT_NXT(a_pose_start, (state_reg == S_IDLE) && in_valid && (func == FUNC_POSE), state_reg == S_MOD, "pose transfer did not start the sequencer")
    `CCHE_ASSERT_IMP(a_idx_commit, cur_reg != $past(cur_reg), $past(state_reg) == S_FIN, "waypoint index changed outside result commit")

endmodule

// ----- design/cche_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cche_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/cche_mul.sv -----
// Registered signed multiplier shared by the sequencer.
// Depends on cche_pkg.
module cche_mul import cche_pkg::*; (
    input  logic  clk,
    input  cdat_t mul_a,
    input  mulb_t mul_b,
    output prod_t prod
);

    prod_t prod_reg;

    // multiply and register
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
    end

    assign prod = prod_reg;

endmodule

// ----- design/cche_cordic.sv -----
// Shared iterative CORDIC: vectoring (magnitude/angle) and rotation (cos/sin).
// One micro-rotation per cycle. Depends on cche_pkg.
module cche_cordic import cche_pkg::*; #(
    parameter int ITERS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cordic_cmd_t  cmd,
    input  cdat_t        x_in,
    input  cdat_t        y_in,
    input  angle_t       z_in,
    output cordic_stat_t stat,
    output cdat_t        x_out,
    output cdat_t        y_out,
    output angle_t       z_out
);

    localparam int KW = $clog2(ITERS);

    typedef enum logic {C_IDLE, C_RUN} cstate_t;

    cstate_t       state_reg;
    logic [KW-1:0] k_reg;
    cdat_t         x_reg;
    cdat_t         y_reg;
    angle_t        z_reg;
    logic          rot_reg;
    logic          neg_reg;
    logic          done_reg;

    cdat_t  xs;
    cdat_t  ys;
    cdat_t  x_step;
    cdat_t  y_step;
    angle_t z_step;
    angle_t a_k;
    logic   ccw;

    // one micro-rotation
    always_comb
    begin
        xs  = x_reg >>> k_reg;
        ys  = y_reg >>> k_reg;
        a_k = atan_lut(5'(k_reg));
        ccw = rot_reg ? (z_reg >= 0) : !(y_reg > 0);
        if (ccw)
        begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - a_k;
        end
        else
        begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + a_k;
        end
    end

    // sequencer: load, iterate, finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
            rot_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (cmd.start)
                    begin
                        k_reg   <= '0;
                        rot_reg <= cmd.rotate;
                        neg_reg <= 1'b0;
                        x_reg   <= x_in;
                        y_reg   <= y_in;
                        if (cmd.rotate)
                        begin
                            // fold into the right half plane
                            state_reg <= C_RUN;
                            if (z_in > HALF_PI_Q16)
                            begin
                                z_reg   <= z_in - PI_Q16;
                                neg_reg <= 1'b1;
                            end
                            else if (z_in < -HALF_PI_Q16)
                            begin
                                z_reg   <= z_in + PI_Q16;
                                neg_reg <= 1'b1;
                            end
                            else
                            begin
                                z_reg <= z_in;
                            end
                        end
                        else if (x_in == '0 && y_in == '0)
                        begin
                            // zero vector: angle and magnitude are zero
                            x_reg    <= '0;
                            y_reg    <= '0;
                            z_reg    <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= C_RUN;
                            if (x_in < 0)
                            begin
                                x_reg <= -x_in;
                                y_reg <= -y_in;
                                z_reg <= (y_in >= 0) ? PI_Q16 : -PI_Q16;
                            end
                            else
                            begin
                                z_reg <= '0;
                            end
                        end
                    end
                end
                C_RUN:
                begin
                    z_reg <= z_step;
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == KW'(ITERS - 1))
                    begin
                        x_reg     <= neg_reg ? -x_step : x_step;
                        y_reg     <= neg_reg ? -y_step : y_step;
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        x_reg <= x_step;
                        y_reg <= y_step;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign stat.done = done_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule
